>>> rtl/hrpc_pkg.sv
// Shared constants, state encodings and event codes of the hinted RUP proof checker.
package hrpc_pkg;

    localparam int HRPC_MEMORY_WORDS      = 65536;
    localparam int HRPC_MAX_CLAUSES       = 65536;
    localparam int HRPC_MAX_VARIABLES     = 65535;
    localparam int HRPC_MAX_CLAUSE_LENGTH = 64;

    localparam int TOKEN_W = 18;
    localparam int ID_W    = 17;

    typedef enum logic [2:0] {
        EV_AXIOM      = 3'd0,
        EV_VERIFIED   = 3'd1,
        EV_UNVERIFIED = 3'd2,
        EV_HINT_ERR   = 3'd3,
        EV_DELETED    = 3'd4,
        EV_SUCCESS    = 3'd5,
        EV_FAIL       = 3'd6
    } t_event;

    typedef enum logic [2:0] {
        PH_START,
        PH_LITS,
        PH_FIRST,
        PH_HINTS,
        PH_BAD_LITS,
        PH_BAD_HINTS,
        PH_DELETE
    } t_phase;

    typedef enum logic [4:0] {
        S_CLEAR,
        S_IDLE,
        S_START_RD,
        S_START_CHK,
        S_WALK_RD,
        S_WALK_WR,
        S_HINT_TAB,
        S_HINT_C,
        S_HINT_RD,
        S_HINT_LIT,
        S_HINT_MAP,
        S_HINT_END,
        S_HINT_PUSH,
        S_ADD_HEAD,
        S_ADD_CHK,
        S_ADD_TOP,
        S_ADD_LINK,
        S_COPY_RD,
        S_COPY_WR,
        S_DEL_TAB,
        S_DEL_C,
        S_DEL_RD,
        S_DEL_CHK,
        S_DEL_END,
        S_DEL_LINK,
        S_EMIT
    } t_state;

endpackage

>>> rtl/hinted_rup_proof_checker.sv
// Top level of the hinted RUP proof checker: token sequencer, clause store and mark map.
//
// The checker takes an LRAT-style proof one signed token per input beat and reports one
// result beat per finished line (axiom added, lemma verified or not, hint error, deletions
// done) and one per verdict request (end_of_proof set). All work runs through a small
// sequencer that walks a literal memory (one write, one read port) one word at a time, so
// the time a beat takes follows the memory walks it triggers: a literal, a terminator or a
// skipped token needs no walk; a line id in range costs a start-table lookup; a deletion id
// costs a table lookup plus a scan of the clause words and, when a clause is deleted, a link
// of the freed block into its free list; a hint costs a table lookup, a literal read and a
// mark lookup per literal of the hinted clause, and a push when it propagates a literal;
// setting or clearing the marks of a lemma walks each lemma literal and each propagated
// literal; adding a clause into a reused block copies it word by word. A result beat
// waits in an output register, so the next token is taken while the previous result is still
// pending, unless that token itself needs the output. After reset the block clears the clause
// table, the mark map and the free-list heads in one pass and holds its input ready low
// meanwhile.
module hinted_rup_proof_checker
    import hrpc_pkg::*;
#(
    parameter int MEMORY_WORDS      = HRPC_MEMORY_WORDS,
    parameter int MAX_CLAUSES       = HRPC_MAX_CLAUSES,
    parameter int MAX_VARIABLES     = HRPC_MAX_VARIABLES,
    parameter int MAX_CLAUSE_LENGTH = HRPC_MAX_CLAUSE_LENGTH
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_s_tvalid,
    output logic        o_s_tready,
    input  logic [23:0] i_s_tdata,   // [17:0] token
    input  logic        i_s_tuser,   // [0] end_of_proof
    output logic        o_m_tvalid,
    input  logic        i_m_tready,
    output logic [23:0] o_m_tdata,   // [16:0] line_clause_id
    output logic [3:0]  o_m_tuser    // [2:0] event_res, [3] refuted_flag
);

    localparam int AW    = $clog2(MEMORY_WORDS);
    localparam int PW    = $clog2(MEMORY_WORDS + MAX_CLAUSE_LENGTH + 2) + 1;
    localparam int CW    = $clog2(MAX_CLAUSES);
    localparam int MAPN  = 2 * MAX_VARIABLES + 1;
    localparam int MIW   = $clog2(MAPN);
    localparam int HW    = $clog2(MAX_CLAUSE_LENGTH);
    localparam int LW    = $clog2(MAX_CLAUSE_LENGTH + 1);
    localparam int SW    = $clog2(MAX_CLAUSE_LENGTH + 2);
    localparam int WW    = (AW > TOKEN_W) ? AW : TOKEN_W;
    localparam int SWP1  = (MAX_CLAUSES > MAPN) ? MAX_CLAUSES : MAPN;
    localparam int SWEEP = (SWP1 > MAX_CLAUSE_LENGTH) ? SWP1 : MAX_CLAUSE_LENGTH;
    localparam int SWW   = $clog2(SWEEP + 1);

    localparam logic [PW-1:0] MW_P  = PW'(MEMORY_WORDS);
    localparam logic [LW-1:0] MCL_L = LW'(MAX_CLAUSE_LENGTH);
    localparam logic [SW-1:0] MCL_S = SW'(MAX_CLAUSE_LENGTH);

    // Mark map address of a literal; zero for a literal out of range.
    function automatic logic [MIW-1:0] f_map_index(input logic signed [TOKEN_W-1:0] lit);
        logic [TOKEN_W-1:0] mag;
        logic [TOKEN_W:0]   dbl;
        mag = lit[TOKEN_W-1] ? TOKEN_W'(-lit) : TOKEN_W'(lit);
        dbl = {mag, 1'b0};
        if (lit == '0 || 32'(mag) > 32'(MAX_VARIABLES)) begin
            return '0;
        end else if (lit[TOKEN_W-1]) begin
            return MIW'(dbl);
        end else begin
            return MIW'(dbl - (TOKEN_W+1)'(1));
        end
    endfunction

    function automatic logic f_id_ok(input logic signed [TOKEN_W-1:0] t);
        return !t[TOKEN_W-1] && (t != '0) && (32'(t[ID_W-1:0]) <= 32'(MAX_CLAUSES));
    endfunction

    function automatic logic [CW-1:0] f_tab_addr(input logic [ID_W-1:0] id);
        return CW'(id - ID_W'(1));
    endfunction

    // ---------------------------------------------------------------- registers
    t_state                      r_state, n_state;
    t_phase                      r_phase;
    logic [SWW-1:0]              r_sweep;
    logic [PW-1:0]               r_wp;
    logic [LW-1:0]               r_len;
    logic [PW-1:0]               r_trail;
    logic                        r_conflict;
    logic                        r_refuted;
    logic [ID_W-1:0]             r_line_id;
    logic signed [TOKEN_W-1:0]   r_tok;
    logic signed [TOKEN_W-1:0]   r_lit;
    logic signed [TOKEN_W-1:0]   r_unit;
    logic [PW-1:0]               r_addr;
    logic [PW-1:0]               r_end;
    logic [PW-1:0]               r_skip;
    logic [PW-1:0]               r_dst;
    logic [PW-1:0]               r_c;
    logic [SW-1:0]               r_cnt;
    logic [1:0]                  r_count;
    logic                        r_mark_val;
    logic                        r_do_add;
    t_event                      r_ev;
    logic [ID_W-1:0]             r_emit_id;
    logic                        r_o_valid;
    t_event                      r_o_ev;
    logic [ID_W-1:0]             r_o_id;
    logic                        r_o_ref;

    // ---------------------------------------------------------------- memory ports
    logic             lm_we;
    logic [AW-1:0]    lm_waddr, lm_raddr;
    logic [WW-1:0]    lm_wdata, lm_q;
    logic             tb_we;
    logic [CW-1:0]    tb_waddr, tb_raddr;
    logic [AW-1:0]    tb_wdata, tb_q;
    logic             mp_we;
    logic [MIW-1:0]   mp_waddr, mp_raddr;
    logic             mp_wdata, mp_q;
    logic             hd_we;
    logic [HW-1:0]    hd_waddr, hd_raddr;
    logic [AW-1:0]    hd_wdata, hd_q;

    hrpc_ram #(.DEPTH(MEMORY_WORDS), .WIDTH(WW)) u_lit_mem (
        .i_clk(i_clk), .i_we(lm_we), .i_waddr(lm_waddr), .i_wdata(lm_wdata),
        .i_raddr(lm_raddr), .o_rdata(lm_q)
    );
    hrpc_ram #(.DEPTH(MAX_CLAUSES), .WIDTH(AW)) u_start_tab (
        .i_clk(i_clk), .i_we(tb_we), .i_waddr(tb_waddr), .i_wdata(tb_wdata),
        .i_raddr(tb_raddr), .o_rdata(tb_q)
    );
    hrpc_ram #(.DEPTH(MAPN), .WIDTH(1)) u_mark_map (
        .i_clk(i_clk), .i_we(mp_we), .i_waddr(mp_waddr), .i_wdata(mp_wdata),
        .i_raddr(mp_raddr), .o_rdata(mp_q)
    );
    hrpc_ram #(.DEPTH(MAX_CLAUSE_LENGTH), .WIDTH(AW)) u_free_heads (
        .i_clk(i_clk), .i_we(hd_we), .i_waddr(hd_waddr), .i_wdata(hd_wdata),
        .i_raddr(hd_raddr), .o_rdata(hd_q)
    );

    // ---------------------------------------------------------------- shared decode
    logic signed [TOKEN_W-1:0] tok;
    logic                      eop;
    logic                      accept;
    logic                      tok_zero;
    logic [PW-1:0]             wp_len;
    logic [PW-1:0]             wp_len1;
    logic                      lits_bad;
    logic signed [TOKEN_W-1:0] lit_q;
    logic [MIW-1:0]            lit_idx;
    logic signed [TOKEN_W-1:0] neg_unit;
    logic [MIW-1:0]            neg_idx;
    logic                      walk_done;
    logic                      hint_stop;
    logic                      del_stop;
    logic                      del_link;
    logic                      out_free;
    logic [PW-1:0]             trail_lim;

    assign tok       = signed'(i_s_tdata[TOKEN_W-1:0]);
    assign eop       = i_s_tuser;
    assign o_s_tready = (r_state == S_IDLE);
    assign accept    = i_s_tvalid && o_s_tready;
    assign tok_zero  = (tok == '0);
    assign wp_len    = r_wp + PW'(r_len);
    assign wp_len1   = wp_len + PW'(1);
    assign lits_bad  = (f_map_index(tok) == '0) || (r_len >= MCL_L) || (wp_len1 >= MW_P);
    assign lit_q     = signed'(lm_q[TOKEN_W-1:0]);
    assign lit_idx   = f_map_index(lit_q);
    assign neg_unit  = -r_unit;
    assign neg_idx   = f_map_index(neg_unit);
    assign walk_done = (r_addr >= r_end);
    assign hint_stop = (r_cnt == MCL_S) || (r_addr >= MW_P);
    assign del_stop  = (r_cnt > MCL_S) || (r_addr >= MW_P);
    assign del_link  = (r_cnt != '0) && (r_cnt <= MCL_S);
    assign out_free  = !r_o_valid || i_m_tready;
    assign trail_lim = (r_trail < MW_P) ? r_trail : MW_P;

    // ---------------------------------------------------------------- next state
    always_comb begin
        n_state = r_state;
        case (r_state)
            S_CLEAR: begin
                if (r_sweep == SWW'(SWEEP - 1)) n_state = S_IDLE;
            end
            S_IDLE: begin
                if (accept) begin
                    if (eop) begin
                        n_state = S_EMIT;
                    end else begin
                        case (r_phase)
                            PH_START:     if (!tok_zero && f_id_ok(tok)) n_state = S_START_RD;
                            PH_FIRST:     n_state = tok_zero ? S_ADD_HEAD : S_WALK_RD;
                            PH_HINTS: begin
                                if (tok_zero)         n_state = S_WALK_RD;
                                else if (!r_conflict) n_state = S_HINT_TAB;
                            end
                            PH_BAD_HINTS: if (tok_zero) n_state = S_WALK_RD;
                            PH_DELETE:    n_state = tok_zero ? S_EMIT : S_DEL_TAB;
                            default:      n_state = S_IDLE;
                        endcase
                    end
                end
            end
            S_START_RD:  n_state = S_START_CHK;
            S_START_CHK: n_state = S_IDLE;
            S_WALK_RD: begin
                if (!walk_done)      n_state = S_WALK_WR;
                else if (r_mark_val) n_state = S_HINT_TAB;
                else if (r_do_add)   n_state = S_ADD_HEAD;
                else                 n_state = S_EMIT;
            end
            S_WALK_WR:   n_state = S_WALK_RD;
            S_HINT_TAB:  n_state = f_id_ok(r_tok) ? S_HINT_C : S_IDLE;
            S_HINT_C:    n_state = (tb_q == '0) ? S_IDLE : S_HINT_RD;
            S_HINT_RD:   n_state = hint_stop ? S_HINT_END : S_HINT_LIT;
            S_HINT_LIT: begin
                if (lit_q == '0)         n_state = S_HINT_END;
                else if (lit_idx == '0)  n_state = S_IDLE;
                else                     n_state = S_HINT_MAP;
            end
            S_HINT_MAP:  n_state = S_HINT_RD;
            S_HINT_END:  n_state = (r_count == 2'd1) ? S_HINT_PUSH : S_IDLE;
            S_HINT_PUSH: n_state = S_IDLE;
            S_ADD_HEAD:  n_state = (r_len != '0) ? S_ADD_CHK : S_ADD_TOP;
            S_ADD_CHK:   n_state = (hd_q == '0) ? S_ADD_TOP : S_ADD_LINK;
            S_ADD_TOP:   n_state = S_EMIT;
            S_ADD_LINK:  n_state = S_COPY_RD;
            S_COPY_RD:   n_state = (r_cnt > SW'(r_len)) ? S_EMIT : S_COPY_WR;
            S_COPY_WR:   n_state = S_COPY_RD;
            S_DEL_TAB:   n_state = f_id_ok(r_tok) ? S_DEL_C : S_IDLE;
            S_DEL_C:     n_state = (tb_q == '0) ? S_IDLE : S_DEL_RD;
            S_DEL_RD:    n_state = del_stop ? S_DEL_END : S_DEL_CHK;
            S_DEL_CHK:   n_state = (lm_q == '0) ? S_DEL_END : S_DEL_RD;
            S_DEL_END:   n_state = del_link ? S_DEL_LINK : S_IDLE;
            S_DEL_LINK:  n_state = S_IDLE;
            S_EMIT:      if (out_free) n_state = S_IDLE;
            default:     n_state = S_IDLE;
        endcase
    end

    // ---------------------------------------------------------------- memory controls
    always_comb begin
        lm_we    = 1'b0;
        lm_waddr = '0;
        lm_wdata = '0;
        lm_raddr = '0;
        tb_we    = 1'b0;
        tb_waddr = '0;
        tb_wdata = '0;
        tb_raddr = '0;
        mp_we    = 1'b0;
        mp_waddr = '0;
        mp_wdata = 1'b0;
        mp_raddr = '0;
        hd_we    = 1'b0;
        hd_waddr = '0;
        hd_wdata = '0;
        hd_raddr = '0;
        case (r_state)
            S_CLEAR: begin
                tb_we    = (32'(r_sweep) < 32'(MAX_CLAUSES));
                tb_waddr = CW'(r_sweep);
                mp_we    = (32'(r_sweep) < 32'(MAPN));
                mp_waddr = MIW'(r_sweep);
                hd_we    = (32'(r_sweep) < 32'(MAX_CLAUSE_LENGTH));
                hd_waddr = HW'(r_sweep);
            end
            S_IDLE: begin
                // literal and terminator stores of the line being read
                if (accept && !eop && r_phase == PH_LITS) begin
                    lm_waddr = AW'(wp_len);
                    if (!tok_zero) begin
                        lm_we    = !lits_bad;
                        lm_wdata = WW'($unsigned(tok));
                    end else begin
                        lm_we    = (wp_len < MW_P);
                    end
                end
            end
            S_START_RD: tb_raddr = f_tab_addr(r_line_id);
            S_WALK_RD:  lm_raddr = AW'(r_addr);
            S_WALK_WR: begin
                mp_we    = (r_addr != r_skip) && (lit_idx != '0);
                mp_waddr = lit_idx;
                mp_wdata = r_mark_val;
            end
            S_HINT_TAB: tb_raddr = f_tab_addr(r_tok[ID_W-1:0]);
            S_HINT_RD:  lm_raddr = AW'(r_addr);
            S_HINT_LIT: mp_raddr = lit_idx;
            S_HINT_END: mp_raddr = neg_idx;
            S_HINT_PUSH: begin
                if (neg_idx != '0 && !mp_q && r_trail < MW_P) begin
                    lm_we    = 1'b1;
                    lm_waddr = AW'(r_trail);
                    lm_wdata = WW'($unsigned(neg_unit));
                    mp_we    = 1'b1;
                    mp_waddr = neg_idx;
                    mp_wdata = 1'b1;
                end
            end
            S_ADD_HEAD: hd_raddr = HW'(r_len - LW'(1));
            S_ADD_CHK:  lm_raddr = hd_q;
            S_ADD_TOP: begin
                tb_we    = 1'b1;
                tb_waddr = f_tab_addr(r_line_id);
                tb_wdata = AW'(r_wp);
            end
            S_ADD_LINK: begin
                hd_we    = 1'b1;
                hd_waddr = HW'(r_len - LW'(1));
                hd_wdata = AW'(lm_q);
                tb_we    = 1'b1;
                tb_waddr = f_tab_addr(r_line_id);
                tb_wdata = AW'(r_dst);
            end
            S_COPY_RD:  lm_raddr = AW'(r_wp + PW'(r_cnt));
            S_COPY_WR: begin
                lm_we    = 1'b1;
                lm_waddr = AW'(r_dst + PW'(r_cnt));
                lm_wdata = lm_q;
            end
            S_DEL_TAB:  tb_raddr = f_tab_addr(r_tok[ID_W-1:0]);
            S_DEL_C: begin
                tb_we    = (tb_q != '0);
                tb_waddr = f_tab_addr(r_tok[ID_W-1:0]);
            end
            S_DEL_RD:   lm_raddr = AW'(r_addr);
            S_DEL_END:  hd_raddr = HW'(r_cnt - SW'(1));
            S_DEL_LINK: begin
                lm_we    = 1'b1;
                lm_waddr = AW'(r_c);
                lm_wdata = WW'(hd_q);
                hd_we    = 1'b1;
                hd_waddr = HW'(r_cnt - SW'(1));
                hd_wdata = AW'(r_c);
            end
            default: begin
            end
        endcase
    end

    // ---------------------------------------------------------------- datapath and control
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state    <= S_CLEAR;
            r_phase    <= PH_START;
            r_sweep    <= '0;
            r_wp       <= PW'(1);
            r_len      <= '0;
            r_trail    <= '0;
            r_conflict <= 1'b0;
            r_refuted  <= 1'b0;
            r_line_id  <= '0;
            r_o_valid  <= 1'b0;
        end else begin
            r_state <= n_state;
            // load a new result beat from S_EMIT, otherwise drop the held one once taken
            if (r_state == S_EMIT && out_free) r_o_valid <= 1'b1;
            else if (i_m_tready)               r_o_valid <= 1'b0;
            case (r_state)
                S_CLEAR: r_sweep <= r_sweep + SWW'(1);
                S_IDLE: begin
                    if (accept && eop) begin
                        r_ev      <= r_refuted ? EV_SUCCESS : EV_FAIL;
                        r_emit_id <= '0;
                    end else if (accept) begin
                        r_tok <= tok;
                        case (r_phase)
                            PH_START: begin
                                if (tok_zero) begin
                                    r_phase <= PH_DELETE;
                                end else begin
                                    r_line_id  <= f_id_ok(tok) ? tok[ID_W-1:0] : '0;
                                    r_len      <= '0;
                                    r_conflict <= 1'b0;
                                    if (!f_id_ok(tok)) r_phase <= PH_BAD_LITS;
                                end
                            end
                            PH_LITS: begin
                                if (!tok_zero) begin
                                    if (lits_bad) r_phase <= PH_BAD_LITS;
                                    else          r_len   <= r_len + LW'(1);
                                end else begin
                                    r_trail <= wp_len1;
                                    r_phase <= (wp_len >= MW_P) ? PH_BAD_HINTS : PH_FIRST;
                                end
                            end
                            PH_BAD_LITS: begin
                                if (tok_zero) begin
                                    r_trail <= wp_len1;
                                    r_phase <= PH_BAD_HINTS;
                                end
                            end
                            PH_FIRST: begin
                                if (tok_zero) begin
                                    r_phase   <= PH_START;
                                    r_ev      <= EV_AXIOM;
                                    r_emit_id <= r_line_id;
                                end else begin
                                    // mark the lemma literals, then check the first hint
                                    r_mark_val <= 1'b1;
                                    r_addr     <= r_wp;
                                    r_end      <= wp_len;
                                    r_skip     <= wp_len;
                                end
                            end
                            PH_HINTS: begin
                                if (tok_zero) begin
                                    r_phase    <= PH_START;
                                    r_ev       <= r_conflict ? EV_VERIFIED : EV_UNVERIFIED;
                                    r_emit_id  <= r_line_id;
                                    r_do_add   <= r_conflict;
                                    if (r_conflict && r_len == '0) r_refuted <= 1'b1;
                                    r_mark_val <= 1'b0;
                                    r_addr     <= r_wp;
                                    r_end      <= trail_lim;
                                    r_skip     <= wp_len;
                                end
                            end
                            PH_BAD_HINTS: begin
                                if (tok_zero) begin
                                    r_phase    <= PH_START;
                                    r_ev       <= EV_HINT_ERR;
                                    r_emit_id  <= r_line_id;
                                    r_do_add   <= 1'b0;
                                    r_mark_val <= 1'b0;
                                    r_addr     <= r_wp;
                                    r_end      <= trail_lim;
                                    r_skip     <= wp_len;
                                end
                            end
                            PH_DELETE: begin
                                if (tok_zero) begin
                                    r_phase   <= PH_START;
                                    r_ev      <= EV_DELETED;
                                    r_emit_id <= '0;
                                end
                            end
                            default: r_phase <= PH_START;
                        endcase
                    end
                end
                S_START_CHK: r_phase <= (tb_q == '0) ? PH_LITS : PH_BAD_LITS;
                S_WALK_RD: begin
                    if (walk_done && !r_mark_val) r_conflict <= 1'b0;
                end
                S_WALK_WR: r_addr <= r_addr + PW'(1);
                S_HINT_TAB: begin
                    if (!f_id_ok(r_tok)) r_phase <= PH_BAD_HINTS;
                end
                S_HINT_C: begin
                    if (tb_q == '0) r_phase <= PH_BAD_HINTS;
                    r_addr  <= PW'(tb_q);
                    r_cnt   <= '0;
                    r_count <= '0;
                end
                S_HINT_LIT: begin
                    r_lit <= lit_q;
                    if (lit_q != '0 && lit_idx == '0) r_phase <= PH_BAD_HINTS;
                end
                S_HINT_MAP: begin
                    if (!mp_q) begin
                        r_unit <= r_lit;
                        if (r_count != 2'd2) r_count <= r_count + 2'd1;
                    end
                    r_addr <= r_addr + PW'(1);
                    r_cnt  <= r_cnt + SW'(1);
                end
                S_HINT_END: begin
                    if (r_count == 2'd0) begin
                        r_conflict <= 1'b1;
                        r_phase    <= PH_HINTS;
                    end else if (r_count == 2'd2) begin
                        r_phase <= PH_BAD_HINTS;
                    end
                end
                S_HINT_PUSH: begin
                    if (neg_idx != '0 && !mp_q && r_trail >= MW_P) begin
                        r_phase <= PH_BAD_HINTS;
                    end else begin
                        r_phase <= PH_HINTS;
                        if (neg_idx != '0 && !mp_q) r_trail <= r_trail + PW'(1);
                    end
                end
                S_ADD_CHK:  r_dst <= PW'(hd_q);
                S_ADD_TOP:  r_wp <= wp_len1;
                S_ADD_LINK: r_cnt <= '0;
                S_COPY_WR:  r_cnt <= r_cnt + SW'(1);
                S_DEL_C: begin
                    r_c    <= PW'(tb_q);
                    r_addr <= PW'(tb_q);
                    r_cnt  <= '0;
                end
                S_DEL_CHK: begin
                    if (lm_q != '0) begin
                        r_cnt  <= r_cnt + SW'(1);
                        r_addr <= r_addr + PW'(1);
                    end
                end
                S_EMIT: begin
                    if (out_free) begin
                        r_o_ev    <= r_ev;
                        r_o_id    <= r_emit_id;
                        r_o_ref   <= r_refuted;
                    end
                end
                default: begin
                end
            endcase
        end
    end

    assign o_m_tvalid = r_o_valid;
    assign o_m_tdata  = {(24 - ID_W)'(0), r_o_id};
    assign o_m_tuser  = {r_o_ref, r_o_ev};

    // ---------------------------------------------------------------- assertions
    a_no_result_in_sweep: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_CLEAR) |-> !r_o_valid)
        else $error("result beat during table sweep");

    a_count_saturates: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count != 2'd3)
        else $error("open literal count beyond saturation");

    a_verdict_matches_flag: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_o_valid && (r_o_ev == EV_SUCCESS || r_o_ev == EV_FAIL)) |->
        (r_o_ref == (r_o_ev == EV_SUCCESS)))
        else $error("verdict disagrees with refuted flag");

    a_refuted_sticks: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $past(r_refuted) && $past(i_rst_n) |-> r_refuted)
        else $error("refuted flag dropped");

    a_len_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_len <= MCL_L)
        else $error("lemma length beyond clause limit");

endmodule

>>> rtl/hrpc_ram.sv
// Single write port, single registered read port RAM.
module hrpc_ram #(
    parameter int DEPTH = 256,
    parameter int WIDTH = 8
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_q;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_q <= r_mem[i_raddr];
    end

    assign o_rdata = r_q;

endmodule

>>> tb/sv/testbench.sv
// Self-checking testbench for the hinted RUP proof checker: directed proof lines, then random proofs.
module testbench;
    import hrpc_pkg::*;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int IDLE_LIMIT    = 400000;  // covers the post-reset clearing pass and slow hints
    localparam int RANDOM_TOKENS = 1500;
    localparam int MAP_DEPTH     = 2 * HRPC_MAX_VARIABLES + 1;

    logic        i_clk      = 1'b0;
    logic        i_rst_n    = 1'b0;
    logic        i_s_tvalid = 1'b0;
    logic        o_s_tready;
    logic [23:0] i_s_tdata  = '0;   // [17:0] token
    logic        i_s_tuser  = 1'b0; // [0] end_of_proof
    logic        o_m_tvalid;
    logic        i_m_tready = 1'b0;
    logic [23:0] o_m_tdata;         // [16:0] line_clause_id
    logic [3:0]  o_m_tuser;         // [2:0] event_res, [3] refuted_flag

    hinted_rup_proof_checker dut (.*);

    always #5 i_clk = ~i_clk;

    // One expected result beat.
    typedef struct packed {
        t_event      ev;
        logic [16:0] cid;
        logic        rf;
    } t_verdict;

    t_verdict verdict_q[$];
    int       mismatches = 0;

    // Shadow copy of the checker state, advanced as each token is issued.
    int          lit_mem  [HRPC_MEMORY_WORDS];
    int unsigned start_tab[HRPC_MAX_CLAUSES];
    bit          false_map[MAP_DEPTH];
    int unsigned free_head[HRPC_MAX_CLAUSE_LENGTH];
    int unsigned wr_ptr, live_clauses, lemma_len, trail_top, line_cid;
    bit          conflict, refuted;
    t_phase      phase;

    function automatic int mark_slot(int lit);
        if (lit > 0 && lit <= HRPC_MAX_VARIABLES) return 2 * lit - 1;
        if (lit < 0 && lit >= -HRPC_MAX_VARIABLES) return -2 * lit;
        return 0;
    endfunction

    function automatic bit id_valid(int id);
        return id >= 1 && id <= HRPC_MAX_CLAUSES;
    endfunction

    function automatic void mark_lemma(bit v);
        for (int unsigned i = 0; i < lemma_len; i++) begin
            if (wr_ptr + i >= HRPC_MEMORY_WORDS) break;
            false_map[mark_slot(lit_mem[wr_ptr + i])] = v;
        end
        false_map[0] = 1'b0;
    endfunction

    // Drop the lemma's own marks and every propagated literal on the trail.
    function automatic void unmark_all();
        mark_lemma(1'b0);
        for (int unsigned a = wr_ptr + lemma_len + 1; a < trail_top && a < HRPC_MEMORY_WORDS; a++)
            false_map[mark_slot(lit_mem[a])] = 1'b0;
        conflict = 1'b0;
    endfunction

    // Commit the clause at the write pointer, into a recycled block of its length if one exists.
    function automatic void store_clause();
        int unsigned dst;
        dst = wr_ptr;
        if (lemma_len >= 1 && lemma_len <= HRPC_MAX_CLAUSE_LENGTH && free_head[lemma_len-1] != 0) begin
            dst = free_head[lemma_len-1];
            free_head[lemma_len-1] = lit_mem[dst];
            for (int unsigned i = 0; i <= lemma_len; i++) lit_mem[dst + i] = lit_mem[wr_ptr + i];
        end else begin
            wr_ptr += lemma_len + 1;
        end
        if (id_valid(line_cid)) start_tab[line_cid - 1] = dst;
        live_clauses++;
    endfunction

    // Unit-propagate one hint clause; return 1 on a hint error.
    function automatic bit propagate_hint(int hid);
        int unsigned c, a, open_cnt, n;
        int lit, unit_lit;
        open_cnt = 0;
        unit_lit = 0;
        if (!id_valid(hid)) return 1'b1;
        c = start_tab[hid - 1];
        if (c == 0) return 1'b1;
        for (int unsigned k = 0; k < HRPC_MAX_CLAUSE_LENGTH; k++) begin
            a = c + k;
            if (a >= HRPC_MEMORY_WORDS) break;
            lit = lit_mem[a];
            if (lit == 0) break;
            if (mark_slot(lit) == 0) return 1'b1;
            if (!false_map[mark_slot(lit)]) begin
                open_cnt++;
                unit_lit = lit;
            end
        end
        if (open_cnt == 0) begin
            conflict = 1'b1;
            return 1'b0;
        end
        if (open_cnt > 1) return 1'b1;
        n = mark_slot(-unit_lit);
        if (n != 0 && !false_map[n]) begin
            if (trail_top >= HRPC_MEMORY_WORDS) return 1'b1;
            lit_mem[trail_top++] = -unit_lit;
            false_map[n] = 1'b1;
        end
        return 1'b0;
    endfunction

    function automatic void drop_clause(int id);
        int unsigned c, s;
        if (!id_valid(id)) return;
        c = start_tab[id - 1];
        if (c == 0) return;
        start_tab[id - 1] = 0;
        live_clauses--;
        s = 0;
        while (s <= HRPC_MAX_CLAUSE_LENGTH && c + s < HRPC_MEMORY_WORDS && lit_mem[c + s] != 0) s++;
        if (s >= 1 && s <= HRPC_MAX_CLAUSE_LENGTH) begin
            lit_mem[c] = free_head[s - 1];
            free_head[s - 1] = c;
        end
    endfunction

    function automatic void post_verdict(t_event ev, int unsigned cid);
        t_verdict v;
        v.ev  = ev;
        v.cid = cid[16:0];
        v.rf  = refuted;
        verdict_q.push_back(v);
    endfunction

    // Advance the shadow state by one beat and queue any result it causes.
    function automatic void advance_checker(int tok, bit eop);
        int unsigned len;
        len = lemma_len;
        if (eop) begin
            post_verdict(refuted ? EV_SUCCESS : EV_FAIL, 0);
            return;
        end
        case (phase)
            PH_START: begin
                if (tok == 0) begin
                    phase = PH_DELETE;
                end else begin
                    line_cid  = id_valid(tok) ? tok : 0;
                    lemma_len = 0;
                    conflict  = 1'b0;
                    phase = (line_cid != 0 && start_tab[line_cid - 1] == 0) ? PH_LITS : PH_BAD_LITS;
                end
            end
            PH_LITS: begin
                if (tok != 0) begin
                    if (mark_slot(tok) == 0 || len >= HRPC_MAX_CLAUSE_LENGTH ||
                        wr_ptr + len + 1 >= HRPC_MEMORY_WORDS) begin
                        phase = PH_BAD_LITS;
                    end else begin
                        lit_mem[wr_ptr + len] = tok;
                        lemma_len = len + 1;
                    end
                end else begin
                    trail_top = wr_ptr + len + 1;
                    if (wr_ptr + len >= HRPC_MEMORY_WORDS) begin
                        phase = PH_BAD_HINTS;
                    end else begin
                        lit_mem[wr_ptr + len] = 0;
                        phase = PH_FIRST;
                    end
                end
            end
            PH_BAD_LITS: begin
                if (tok == 0) begin
                    trail_top = wr_ptr + len + 1;
                    phase = PH_BAD_HINTS;
                end
            end
            PH_FIRST: begin
                if (tok == 0) begin
                    store_clause();
                    phase = PH_START;
                    post_verdict(EV_AXIOM, line_cid);
                end else begin
                    mark_lemma(1'b1);
                    phase = propagate_hint(tok) ? PH_BAD_HINTS : PH_HINTS;
                end
            end
            PH_HINTS: begin
                if (tok != 0) begin
                    if (!conflict && propagate_hint(tok)) phase = PH_BAD_HINTS;
                end else begin
                    phase = PH_START;
                    if (conflict) begin
                        unmark_all();
                        store_clause();
                        if (len == 0) refuted = 1'b1;
                        post_verdict(EV_VERIFIED, line_cid);
                    end else begin
                        unmark_all();
                        post_verdict(EV_UNVERIFIED, line_cid);
                    end
                end
            end
            PH_BAD_HINTS: begin
                if (tok == 0) begin
                    unmark_all();
                    phase = PH_START;
                    post_verdict(EV_HINT_ERR, line_cid);
                end
            end
            PH_DELETE: begin
                if (tok == 0) begin
                    phase = PH_START;
                    post_verdict(EV_DELETED, 0);
                end else begin
                    drop_clause(tok);
                end
            end
            default: phase = PH_START;
        endcase
    endfunction

    // ---------------------------------------------------------------- driver
    int quiet_sender = 0;  // beats left in a stretch with no sender gaps

    task automatic send_beat(int tok, bit eop);
        int gap;
        gap = (quiet_sender > 0) ? 0 : $urandom_range(0, 7);
        if (quiet_sender > 0) quiet_sender--;
        else if ($urandom_range(0, 49) == 0) quiet_sender = $urandom_range(20, 60);
        if (gap > 0) begin
            i_s_tvalid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        i_s_tvalid <= 1'b1;
        i_s_tdata  <= {6'b0, tok[17:0]};
        i_s_tuser  <= eop;
        // hold the beat until the handshake completes
        do @(posedge i_clk); while (!o_s_tready);
    endtask

    // Random literal: mostly a handful of variables so hints interact, sometimes any variable.
    function automatic int rand_lit();
        int v;
        v = ($urandom_range(0, 15) == 0) ? $urandom_range(1, HRPC_MAX_VARIABLES)
                                         : $urandom_range(1, 8);
        return $urandom_range(0, 1) ? v : -v;
    endfunction

    function automatic int rand_cid();
        return ($urandom_range(0, 19) == 0) ? $urandom_range(1, HRPC_MAX_CLAUSES)
                                            : $urandom_range(1, 400);
    endfunction

    typedef struct {
        int     tok;
        bit     eop;
        bit     typed;
        t_event ev;
        int     cid;
        bit     rf;
    } t_stim_row;

    // Directed proof: verdict before anything, extreme ids and literals, a bad literal,
    // refutation by the empty lemma, and a deletion.
    t_stim_row directed_rows[] = '{
        '{0,      1, 1, EV_FAIL,     0,     0},
        '{1,      0, 0, EV_AXIOM,    0,     0},
        '{3,      0, 0, EV_AXIOM,    0,     0},
        '{-2,     0, 0, EV_AXIOM,    0,     0},
        '{0,      0, 0, EV_AXIOM,    0,     0},
        '{0,      0, 1, EV_AXIOM,    1,     0},
        '{65536,  0, 0, EV_AXIOM,    0,     0},
        '{65535,  0, 0, EV_AXIOM,    0,     0},
        '{0,      0, 0, EV_AXIOM,    0,     0},
        '{0,      0, 1, EV_AXIOM,    65536, 0},
        '{2,      0, 0, EV_AXIOM,    0,     0},
        '{65536,  0, 0, EV_AXIOM,    0,     0},
        '{0,      0, 0, EV_AXIOM,    0,     0},
        '{0,      0, 1, EV_HINT_ERR, 2,     0},
        '{4,      0, 0, EV_AXIOM,    0,     0},
        '{-65535, 0, 0, EV_AXIOM,    0,     0},
        '{0,      0, 0, EV_AXIOM,    0,     0},
        '{0,      0, 1, EV_AXIOM,    4,     0},
        '{5,      0, 0, EV_AXIOM,    0,     0},
        '{0,      0, 0, EV_AXIOM,    0,     0},
        '{65536,  0, 0, EV_AXIOM,    0,     0},
        '{4,      0, 0, EV_AXIOM,    0,     0},
        '{0,      0, 1, EV_VERIFIED, 5,     1},
        '{0,      0, 0, EV_AXIOM,    0,     0},
        '{65536,  0, 0, EV_AXIOM,    0,     0},
        '{0,      0, 1, EV_DELETED,  0,     1}
    };

    initial begin
        int sent;
        int pick, cid, n, c;
        int line[$];
        int used_ids[$];
        t_verdict typed_v;

        wr_ptr = 1; live_clauses = 0; lemma_len = 0; trail_top = 0; line_cid = 0;
        conflict = 0; refuted = 0; phase = PH_START;
        repeat (6) @(posedge i_clk);
        i_rst_n <= 1'b1;

        foreach (directed_rows[r]) begin
            advance_checker(directed_rows[r].tok, directed_rows[r].eop);
            if (directed_rows[r].typed) begin
                // replace the predicted beat with the hand-written one
                void'(verdict_q.pop_back());
                typed_v.ev  = directed_rows[r].ev;
                typed_v.cid = directed_rows[r].cid[16:0];
                typed_v.rf  = directed_rows[r].rf;
                verdict_q.push_back(typed_v);
            end
            send_beat(directed_rows[r].tok, directed_rows[r].eop);
        end

        sent = 0;
        while (sent < RANDOM_TOKENS) begin
            line.delete();
            pick = $urandom_range(0, 99);
            if (pick < 28) begin
                // axiom
                cid = rand_cid();
                used_ids.push_back(cid);
                line.push_back(cid);
                n = $urandom_range(0, 4);
                repeat (n) line.push_back(rand_lit());
                line.push_back(0);
                line.push_back(0);
            end else if (pick < 58 && used_ids.size() > 0) begin
                // lemma subsumed by a stored clause: hinting that clause gives a conflict
                cid = used_ids[$urandom_range(0, used_ids.size() - 1)];
                line.push_back(rand_cid());
                c = start_tab[cid - 1];
                if (c != 0)
                    for (int k = 0; k < HRPC_MAX_CLAUSE_LENGTH && lit_mem[c + k] != 0; k++)
                        line.push_back(lit_mem[c + k]);
                if ($urandom_range(0, 3) == 0) line.push_back(rand_lit());
                line.push_back(0);
                if ($urandom_range(0, 3) == 0 && used_ids.size() > 0)
                    line.push_back(used_ids[$urandom_range(0, used_ids.size() - 1)]);
                line.push_back(cid);
                if ($urandom_range(0, 1)) line.push_back(rand_cid());
                line.push_back(0);
            end else if (pick < 73) begin
                // lemma with arbitrary hints
                line.push_back(rand_cid());
                n = $urandom_range(0, 3);
                repeat (n) line.push_back(rand_lit());
                line.push_back(0);
                n = $urandom_range(1, 4);
                repeat (n) line.push_back((used_ids.size() > 0 && $urandom_range(0, 4) != 0) ?
                    used_ids[$urandom_range(0, used_ids.size() - 1)] : rand_cid());
                line.push_back(0);
            end else if (pick < 86) begin
                // deletion line, mostly of known ids
                line.push_back(0);
                n = $urandom_range(0, 3);
                repeat (n) line.push_back((used_ids.size() > 0 && $urandom_range(0, 3) != 0) ?
                    used_ids[$urandom_range(0, used_ids.size() - 1)] : rand_cid());
                line.push_back(0);
            end else if (pick < 90) begin
                // verdict request, token content is don't-care
                n = $urandom_range(0, 131071) - 65535;
                advance_checker(n, 1'b1);
                send_beat(n, 1'b1);
                sent++;
            end else if (pick < 98) begin
                // noise across the whole literal and clause id range
                n = $urandom_range(1, 5);
                repeat (n) line.push_back($urandom_range(0, 131071) - 65535);
            end else begin
                // longest legal clause, or one to six literals too many
                cid = rand_cid();
                used_ids.push_back(cid);
                line.push_back(cid);
                n = $urandom_range(0, 1) ? HRPC_MAX_CLAUSE_LENGTH : $urandom_range(65, 70);
                repeat (n) line.push_back(rand_lit());
                line.push_back(0);
                line.push_back(0);
            end
            foreach (line[i]) begin
                advance_checker(line[i], 1'b0);
                send_beat(line[i], 1'b0);
                sent++;
            end
        end
        i_s_tvalid <= 1'b0;

        while (verdict_q.size() != 0) @(posedge i_clk);
        repeat (500) @(posedge i_clk);
        if (mismatches == 0)
            $display("SCOREBOARD CLEAN");
        else
            $display("SCOREBOARD MISMATCH");
        $finish;
    end

    // ---------------------------------------------------------------- monitor
    initial begin
        int stall;
        t_verdict want;
        t_verdict got;
        int quiet_sink;
        quiet_sink = 0;
        forever begin
            stall = (quiet_sink > 0) ? 0 : $urandom_range(0, 7);
            if (quiet_sink > 0) quiet_sink--;
            else if ($urandom_range(0, 29) == 0) quiet_sink = $urandom_range(10, 30);
            if (stall > 0) begin
                i_m_tready <= 1'b0;
                repeat (stall) @(posedge i_clk);
            end
            i_m_tready <= 1'b1;
            do @(posedge i_clk); while (!o_m_tvalid);
            got.ev  = t_event'(o_m_tuser[2:0]);
            got.cid = o_m_tdata[16:0];
            got.rf  = o_m_tuser[3];
            if (verdict_q.size() == 0) begin
                mismatches++;
                if (mismatches <= 10)
                    $display("unexpected result beat: ev=%0d id=%0d refuted=%0b",
                             got.ev, got.cid, got.rf);
            end else begin
                want = verdict_q.pop_front();
                if (got != want) begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display("result mismatch: expected ev=%0d id=%0d refuted=%0b, got ev=%0d id=%0d refuted=%0b",
                                 want.ev, want.cid, want.rf, got.ev, got.cid, got.rf);
                end
            end
        end
    end

    // Watchdog: end the run if neither side moves a beat for too long.
    int idle_cycles = 0;
    always @(posedge i_clk) begin
        if ((i_s_tvalid && o_s_tready) || (o_m_tvalid && i_m_tready)) begin
            idle_cycles <= 0;
        end else begin
            idle_cycles <= idle_cycles + 1;
            if (idle_cycles >= IDLE_LIMIT) begin
                $display("SCOREBOARD MISMATCH");
                $finish;
            end
        end
    end

endmodule

>>> files.f
rtl/hrpc_pkg.sv
rtl/hrpc_ram.sv
rtl/hinted_rup_proof_checker.sv
tb/sv/testbench.sv
